[hdl/llpc_pkg.sv]
package llpc_pkg;
    localparam int DEF_MAX_NODES   = 256;
    localparam int DEF_MAX_EDGES   = 256;
    localparam int DEF_MAX_QUERIES = 64;
    localparam int DEF_LENGTH_BITS = 24;

    localparam int NODE_FIELD_W = 8;
    localparam int CFG_W        = 9;
    localparam int QNUM_W       = 6;
    localparam int RANK_W       = 4;

    localparam logic [CFG_W-1:0]  NODE_COUNT_RESET = 9'd256;
    localparam logic [RANK_W-1:0] RANK_MAX         = 4'd15;

    localparam logic ACT_EDGE  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;
endpackage

[hdl/llpc_if.sv]
interface llpc_req_if #(parameter int LEN_W = 24);
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic [llpc_pkg::NODE_FIELD_W-1:0]   node_a;
    logic [llpc_pkg::NODE_FIELD_W-1:0]   node_b;
    logic [LEN_W-1:0]                    length_or_limit;
    logic                                last;

    modport source (output valid, action, node_a, node_b, length_or_limit, last,
                    input ready);
    modport sink (input valid, action, node_a, node_b, length_or_limit, last,
                  output ready);
endinterface

interface llpc_ans_if;
    logic                          valid;
    logic                          ready;
    logic                          connected;
    logic [llpc_pkg::QNUM_W-1:0]   query_number;
    logic                          dropped;
    logic                          last_answer;

    modport source (output valid, connected, query_number, dropped, last_answer,
                    input ready);
    modport sink (input valid, connected, query_number, dropped, last_answer,
                  output ready);
endinterface

[hdl/llpc_ram.sv]
module llpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hdl/limited_length_path_connectivity.sv]
// connectivity under a length limit: edges and queries are loaded one request
// per cycle; the request flagged last starts the solve if a query is stored, else
// the stored edges and the dropped flag are cleared. for each stored query the
// union-find (parent and rank memories) is swept back to singletons, every stored
// edge shorter than the limit is merged (union by rank), and the two query nodes
// are compared by root. answers then leave in arrival order with query_number, a
// problem-wide dropped flag and last_answer on the final one. every find step
// goes through the single read port of the parent memory. answers leave as
// ans.ready takes them. no request is taken while a problem is being solved or
// answered. a request with a node at or above node_count, or beyond store
// capacity, is not stored and raises dropped.
module limited_length_path_connectivity #(
    parameter int MAX_NODES   = llpc_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES   = llpc_pkg::DEF_MAX_EDGES,
    parameter int MAX_QUERIES = llpc_pkg::DEF_MAX_QUERIES,
    parameter int LENGTH_BITS = llpc_pkg::DEF_LENGTH_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [llpc_pkg::CFG_W-1:0] cfg_wdata,
    llpc_req_if.sink                   req,
    llpc_ans_if.source                 ans
);
    import llpc_pkg::*;

    // widths
    localparam int NB    = $clog2(MAX_NODES);
    localparam int CMP_W = $clog2(MAX_NODES + 1) > CFG_W ? $clog2(MAX_NODES + 1) : CFG_W;
    localparam int EAW   = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1;
    localparam int EFW   = $clog2(MAX_EDGES + 1);
    localparam int QAW   = MAX_QUERIES > 1 ? $clog2(MAX_QUERIES) : 1;
    localparam int QFW   = $clog2(MAX_QUERIES + 1);
    localparam int REC_W = 2 * NB + LENGTH_BITS;

    // sequencer codes
    localparam logic [3:0] S_LOAD = 4'd0;
    localparam logic [3:0] S_QRD  = 4'd1;
    localparam logic [3:0] S_QWT  = 4'd2;
    localparam logic [3:0] S_CLR  = 4'd3;
    localparam logic [3:0] S_ERD  = 4'd4;
    localparam logic [3:0] S_EWT  = 4'd5;
    localparam logic [3:0] S_FRD  = 4'd6;
    localparam logic [3:0] S_FWT  = 4'd7;
    localparam logic [3:0] S_RKA  = 4'd8;
    localparam logic [3:0] S_RKB  = 4'd9;
    localparam logic [3:0] S_UNI  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    // which find is running
    localparam logic [1:0] F_EDGE_A  = 2'd0;
    localparam logic [1:0] F_EDGE_B  = 2'd1;
    localparam logic [1:0] F_QUERY_A = 2'd2;
    localparam logic [1:0] F_QUERY_B = 2'd3;

    logic [3:0]             state_reg, state_next;
    logic [1:0]             phase_reg, phase_next;
    logic [CFG_W-1:0]       node_count_reg;
    logic [EFW-1:0]         efill_reg, efill_next;
    logic [QFW-1:0]         qfill_reg, qfill_next;
    logic                   drop_reg, drop_next;
    logic [MAX_QUERIES-1:0] answer_reg, answer_next;
    logic [QFW-1:0]         qi_reg, qi_next;
    logic [EFW-1:0]         ei_reg, ei_next;
    logic [NB-1:0]          cc_reg, cc_next;
    logic [NB-1:0]          x_reg, x_next;
    logic [NB-1:0]          ra_reg, ra_next;
    logic [NB-1:0]          rb_reg, rb_next;
    logic [NB-1:0]          eb_reg, eb_next;
    logic [NB-1:0]          qa_reg, qa_next;
    logic [NB-1:0]          qb_reg, qb_next;
    logic [LENGTH_BITS-1:0] qlim_reg, qlim_next;
    logic [RANK_W-1:0]      rka_reg, rka_next;

    // memory ports
    logic                   e_we, q_we, p_we, r_we;
    logic [REC_W-1:0]       rec_wdata, e_rdata, q_rdata;
    logic [QAW-1:0]         q_raddr;
    logic [NB-1:0]          p_waddr, p_wdata, p_raddr, p_rdata;
    logic [NB-1:0]          r_waddr, r_raddr;
    logic [RANK_W-1:0]      r_wdata, r_rdata;

    // request decode
    logic                   accept;
    logic [CMP_W-1:0]       lim;
    logic                   nodes_ok;
    logic [LENGTH_BITS-1:0] req_len;

    assign lim = (CMP_W'(node_count_reg) < CMP_W'(MAX_NODES)) ?
                 CMP_W'(node_count_reg) : CMP_W'(MAX_NODES);
    assign nodes_ok = (CMP_W'(req.node_a) < lim) && (CMP_W'(req.node_b) < lim);
    assign req_len  = LENGTH_BITS'(req.length_or_limit);
    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == S_LOAD);

    assign rec_wdata = {NB'(req.node_a), NB'(req.node_b), req_len};
    assign e_we = accept && req.action == ACT_EDGE && nodes_ok &&
                  efill_reg < EFW'(MAX_EDGES);
    assign q_we = accept && req.action == ACT_QUERY && nodes_ok &&
                  qfill_reg < QFW'(MAX_QUERIES);
    assign q_raddr = qi_reg[QAW-1:0];
    assign p_raddr = x_reg;

    llpc_ram #(.WIDTH(REC_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk(clk), .we(e_we), .waddr(efill_reg[EAW-1:0]), .wdata(rec_wdata),
        .raddr(ei_reg[EAW-1:0]), .rdata(e_rdata)
    );

    llpc_ram #(.WIDTH(REC_W), .DEPTH(MAX_QUERIES)) u_query_ram (
        .clk(clk), .we(q_we), .waddr(qfill_reg[QAW-1:0]), .wdata(rec_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    llpc_ram #(.WIDTH(NB), .DEPTH(MAX_NODES)) u_parent_ram (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    llpc_ram #(.WIDTH(RANK_W), .DEPTH(MAX_NODES)) u_rank_ram (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(r_rdata)
    );

    // answer channel straight from the held registers
    assign ans.valid        = (state_reg == S_OUT);
    assign ans.connected    = answer_reg[qi_reg[QAW-1:0]];
    assign ans.query_number = QNUM_W'(qi_reg);
    assign ans.dropped      = drop_reg;
    assign ans.last_answer  = (qi_reg == qfill_reg - QFW'(1));

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        efill_next  = efill_reg;
        qfill_next  = qfill_reg;
        drop_next   = drop_reg;
        answer_next = answer_reg;
        qi_next     = qi_reg;
        ei_next     = ei_reg;
        cc_next     = cc_reg;
        x_next      = x_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        eb_next     = eb_reg;
        qa_next     = qa_reg;
        qb_next     = qb_reg;
        qlim_next   = qlim_reg;
        rka_next    = rka_reg;
        p_we        = 1'b0;
        p_waddr     = cc_reg;
        p_wdata     = cc_reg;
        r_we        = 1'b0;
        r_waddr     = cc_reg;
        r_wdata     = '0;
        r_raddr     = ra_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (e_we)
                    begin
                        efill_next = efill_reg + EFW'(1);
                    end
                    if (q_we)
                    begin
                        qfill_next = qfill_reg + QFW'(1);
                    end
                    if (!e_we && !q_we)
                    begin
                        drop_next = 1'b1;
                    end
                    if (req.last)
                    begin
                        qi_next = '0;
                        if (qfill_next == '0)
                        begin
                            // nothing to answer: start over
                            efill_next = '0;
                            drop_next  = 1'b0;
                        end
                        else
                        begin
                            state_next = S_QRD;
                        end
                    end
                end
            end
            S_QRD:
            begin
                state_next = S_QWT;
            end
            S_QWT:
            begin
                qa_next    = q_rdata[REC_W-1 -: NB];
                qb_next    = q_rdata[LENGTH_BITS +: NB];
                qlim_next  = q_rdata[LENGTH_BITS-1:0];
                cc_next    = '0;
                state_next = S_CLR;
            end
            S_CLR:
            begin
                // back to singleton sets
                p_we    = 1'b1;
                r_we    = 1'b1;
                cc_next = cc_reg + NB'(1);
                if (cc_reg == NB'(MAX_NODES - 1))
                begin
                    ei_next    = '0;
                    state_next = S_ERD;
                end
            end
            S_ERD:
            begin
                if (ei_reg == efill_reg)
                begin
                    x_next     = qa_reg;
                    phase_next = F_QUERY_A;
                    state_next = S_FRD;
                end
                else
                begin
                    state_next = S_EWT;
                end
            end
            S_EWT:
            begin
                eb_next = e_rdata[LENGTH_BITS +: NB];
                if (e_rdata[LENGTH_BITS-1:0] < qlim_reg)
                begin
                    x_next     = e_rdata[REC_W-1 -: NB];
                    phase_next = F_EDGE_A;
                    state_next = S_FRD;
                end
                else
                begin
                    ei_next    = ei_reg + EFW'(1);
                    state_next = S_ERD;
                end
            end
            S_FRD:
            begin
                state_next = S_FWT;
            end
            S_FWT:
            begin
                if (p_rdata != x_reg)
                begin
                    x_next     = p_rdata;
                    state_next = S_FRD;
                end
                else
                begin
                    case (phase_reg)
                        F_EDGE_A:
                        begin
                            ra_next    = x_reg;
                            x_next     = eb_reg;
                            phase_next = F_EDGE_B;
                            state_next = S_FRD;
                        end
                        F_EDGE_B:
                        begin
                            rb_next = x_reg;
                            if (ra_reg == x_reg)
                            begin
                                ei_next    = ei_reg + EFW'(1);
                                state_next = S_ERD;
                            end
                            else
                            begin
                                state_next = S_RKA;
                            end
                        end
                        F_QUERY_A:
                        begin
                            ra_next    = x_reg;
                            x_next     = qb_reg;
                            phase_next = F_QUERY_B;
                            state_next = S_FRD;
                        end
                        default:
                        begin
                            answer_next[qi_reg[QAW-1:0]] = (ra_reg == x_reg);
                            if (qi_reg + QFW'(1) == qfill_reg)
                            begin
                                qi_next    = '0;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                qi_next    = qi_reg + QFW'(1);
                                state_next = S_QRD;
                            end
                        end
                    endcase
                end
            end
            S_RKA:
            begin
                r_raddr    = ra_reg;
                state_next = S_RKB;
            end
            S_RKB:
            begin
                r_raddr    = rb_reg;
                rka_next   = r_rdata;
                state_next = S_UNI;
            end
            S_UNI:
            begin
                // union by rank, rank saturates
                p_we = 1'b1;
                if (rka_reg < r_rdata)
                begin
                    p_waddr = ra_reg;
                    p_wdata = rb_reg;
                end
                else
                begin
                    p_waddr = rb_reg;
                    p_wdata = ra_reg;
                    if (rka_reg == r_rdata && rka_reg != RANK_MAX)
                    begin
                        r_we    = 1'b1;
                        r_waddr = ra_reg;
                        r_wdata = rka_reg + RANK_W'(1);
                    end
                end
                ei_next    = ei_reg + EFW'(1);
                state_next = S_ERD;
            end
            S_OUT:
            begin
                if (ans.ready)
                begin
                    if (ans.last_answer)
                    begin
                        efill_next  = '0;
                        qfill_next  = '0;
                        drop_next   = 1'b0;
                        answer_next = '0;
                        qi_next     = '0;
                        state_next  = S_LOAD;
                    end
                    else
                    begin
                        qi_next = qi_reg + QFW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            phase_reg      <= F_EDGE_A;
            node_count_reg <= NODE_COUNT_RESET;
            efill_reg      <= '0;
            qfill_reg      <= '0;
            drop_reg       <= 1'b0;
            answer_reg     <= '0;
            qi_reg         <= '0;
            ei_reg         <= '0;
            cc_reg         <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            efill_reg  <= efill_next;
            qfill_reg  <= qfill_next;
            drop_reg   <= drop_next;
            answer_reg <= answer_next;
            qi_reg     <= qi_next;
            ei_reg     <= ei_next;
            cc_reg     <= cc_next;
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        ra_reg   <= ra_next;
        rb_reg   <= rb_next;
        eb_reg   <= eb_next;
        qa_reg   <= qa_next;
        qb_reg   <= qb_next;
        qlim_reg <= qlim_next;
        rka_reg  <= rka_next;
    end
endmodule

[dv/limited_length_path_connectivity_tb.sv]
module limited_length_path_connectivity_tb;
    import llpc_pkg::*;

    localparam int LEN_W        = DEF_LENGTH_BITS;
    localparam int NODES        = DEF_MAX_NODES;
    localparam int EDGE_CAP     = DEF_MAX_EDGES;
    localparam int QUERY_CAP    = DEF_MAX_QUERIES;
    // a solve sweeps the whole node memory once per query
    localparam int STALL_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 2000;
    // longer than the solve of the held problem, so its answers pile up
    // while the next problem is already being offered
    localparam int HOLD_CYCLES  = 6000;

    // one request as the sender sees it; typed_conn is a hand-written answer
    // (-1 when the predictor decides) and cfg a node_count to load first
    typedef struct {
        logic             action;
        logic [7:0]       node_a;
        logic [7:0]       node_b;
        logic [LEN_W-1:0] len;
        logic             last;
        int               typed_conn;
        int               cfg;
    } request_t;

    typedef struct {
        logic       connected;
        logic [5:0] query_number;
        logic       dropped;
        logic       last_answer;
    } answer_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    llpc_req_if #(.LEN_W(LEN_W)) req_if ();
    llpc_ans_if                  ans_if ();

    limited_length_path_connectivity dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_if.sink),
        .ans       (ans_if.source)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------
    // predictor: own copy of the stores and of the union-find
    // ---------------------------------------------------------------
    logic [7:0]       edge_a [EDGE_CAP];
    logic [7:0]       edge_b [EDGE_CAP];
    logic [LEN_W-1:0] edge_len [EDGE_CAP];
    int               edge_count;
    logic [7:0]       query_a [QUERY_CAP];
    logic [7:0]       query_b [QUERY_CAP];
    logic [LEN_W-1:0] query_limit [QUERY_CAP];
    int               query_typed [QUERY_CAP];
    int               query_count;
    logic [7:0]       parent_of [NODES];
    logic [3:0]       rank_of [NODES];
    logic             any_dropped;
    logic [CFG_W-1:0] node_count;

    answer_t answers_due[$];

    function automatic void clear_problem();
        edge_count  = 0;
        query_count = 0;
        any_dropped = 1'b0;
        for (int i = 0; i < NODES; i++)
        begin
            parent_of[i] = i[7:0];
            rank_of[i]   = '0;
        end
        for (int i = 0; i < QUERY_CAP; i++)
            query_typed[i] = -1;
    endfunction

    // find with full path compression
    function automatic logic [7:0] find_root(logic [7:0] x);
        logic [7:0] r;
        logic [7:0] c;
        logic [7:0] nx;
        r = x;
        while (parent_of[r] != r)
            r = parent_of[r];
        c = x;
        while (parent_of[c] != c)
        begin
            nx = parent_of[c];
            parent_of[c] = r;
            c = nx;
        end
        return r;
    endfunction

    // union by rank, rank saturates at the top value
    function automatic void merge_nodes(logic [7:0] u, logic [7:0] v);
        logic [7:0] ru;
        logic [7:0] rv;
        ru = find_root(u);
        rv = find_root(v);
        if (ru == rv)
            return;
        if (rank_of[ru] > rank_of[rv])
            parent_of[rv] = ru;
        else if (rank_of[ru] < rank_of[rv])
            parent_of[ru] = rv;
        else
        begin
            parent_of[rv] = ru;
            if (rank_of[ru] < RANK_MAX)
                rank_of[ru]++;
        end
    endfunction

    // sweep queries in rising limit, merging every edge strictly shorter,
    // then queue one answer per stored query in arrival order
    function automatic void solve_problem();
        int         edge_rank [EDGE_CAP];
        int         query_rank [QUERY_CAP];
        logic [63:0] joined;
        int         k;
        int         j;
        int         p;
        answer_t    a;
        joined = '0;
        for (int i = 0; i < edge_count; i++)
        begin
            k = i;
            j = i;
            while (j > 0 && edge_len[edge_rank[j-1]] > edge_len[k])
            begin
                edge_rank[j] = edge_rank[j-1];
                j--;
            end
            edge_rank[j] = k;
        end
        for (int i = 0; i < query_count; i++)
        begin
            k = i;
            j = i;
            while (j > 0 && query_limit[query_rank[j-1]] > query_limit[k])
            begin
                query_rank[j] = query_rank[j-1];
                j--;
            end
            query_rank[j] = k;
        end
        p = 0;
        for (int i = 0; i < query_count; i++)
        begin
            k = query_rank[i];
            while (p < edge_count && edge_len[edge_rank[p]] < query_limit[k])
            begin
                merge_nodes(edge_a[edge_rank[p]], edge_b[edge_rank[p]]);
                p++;
            end
            if (find_root(query_a[k]) == find_root(query_b[k]))
                joined[k] = 1'b1;
        end
        for (int i = 0; i < query_count; i++)
        begin
            a.connected    = query_typed[i] >= 0 ? query_typed[i][0] : joined[i];
            a.query_number = i[5:0];
            a.dropped      = any_dropped;
            a.last_answer  = (i + 1 == query_count);
            answers_due.insert(answers_due.size(), a);
        end
        clear_problem();
    endfunction

    function automatic void note_request(request_t r);
        int  lim;
        logic ok;
        lim = node_count < NODES ? int'(node_count) : NODES;
        ok  = r.node_a < lim && r.node_b < lim;
        if (r.action == ACT_EDGE)
        begin
            if (ok && edge_count < EDGE_CAP)
            begin
                edge_a[edge_count]   = r.node_a;
                edge_b[edge_count]   = r.node_b;
                edge_len[edge_count] = r.len;
                edge_count++;
            end
            else
                any_dropped = 1'b1;
        end
        else
        begin
            if (ok && query_count < QUERY_CAP)
            begin
                query_a[query_count]     = r.node_a;
                query_b[query_count]     = r.node_b;
                query_limit[query_count] = r.len;
                query_typed[query_count] = r.typed_conn;
                query_count++;
            end
            else
                any_dropped = 1'b1;
        end
        if (r.last)
            solve_problem();
    endfunction

    // ---------------------------------------------------------------
    // sender, receiver, checker, watchdog
    // ---------------------------------------------------------------
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    bit hold_start;
    int error_count;
    int idle_cycles;
    int sent_requests;

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_start)
        begin
            hold_start = 1'b0;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            ans_if.ready = 1'b0;
        end
        else
            ans_if.ready = rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // compare each answer with the oldest one due; watchdog on no progress
    always @(posedge clk)
    begin
        answer_t e;
        if (ans_if.valid === 1'b1 && ans_if.ready === 1'b1)
        begin
            if (answers_due.size() == 0)
            begin
                $error("answer with none due: query_number %0d", ans_if.query_number);
                error_count++;
            end
            else
            begin
                e = answers_due.pop_front();
                if (ans_if.connected !== e.connected)
                begin
                    $error("connected: expected %0d, actual %0d",
                           e.connected, ans_if.connected);
                    error_count++;
                end
                if (ans_if.query_number !== e.query_number)
                begin
                    $error("query_number: expected %0d, actual %0d",
                           e.query_number, ans_if.query_number);
                    error_count++;
                end
                if (ans_if.dropped !== e.dropped)
                begin
                    $error("dropped: expected %0d, actual %0d",
                           e.dropped, ans_if.dropped);
                    error_count++;
                end
                if (ans_if.last_answer !== e.last_answer)
                begin
                    $error("last_answer: expected %0d, actual %0d",
                           e.last_answer, ans_if.last_answer);
                    error_count++;
                end
            end
        end
        if ((ans_if.valid === 1'b1 && ans_if.ready === 1'b1) ||
            (req_if.valid === 1'b1 && req_if.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == STALL_LIMIT)
        begin
            $display("limited_length_path_connectivity_tb: done, errors");
            $finish;
        end
    end

    // offer one request, called at a falling edge, returns at a falling edge;
    // valid stays high between back-to-back requests
    task automatic send_request(request_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid           = 1'b1;
        req_if.action          = r.action;
        req_if.node_a          = r.node_a;
        req_if.node_b          = r.node_b;
        req_if.length_or_limit = r.len;
        req_if.last            = r.last;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        note_request(r);
        sent_requests++;
        @(negedge clk);
    endtask

    // stop sending until every answer is in, then let the block settle
    task automatic drain();
        req_if.valid = 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_node_count(int value);
        drain();
        cfg_we    = 1'b1;
        cfg_wdata = value[CFG_W-1:0];
        @(posedge clk);
        node_count = value[CFG_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [7:0] pick_node(int span, int bad_pct);
        int lim;
        lim = node_count < NODES ? int'(node_count) : NODES;
        if (lim < NODES && $urandom_range(99) < bad_pct)
            return 8'($urandom_range(NODES - 1, lim));
        return 8'($urandom_range(span - 1, 0));
    endfunction

    // one problem: edges and queries interleaved at random, last on the end
    task automatic run_problem(int n_edges, int n_queries, int span, int bad_pct);
        request_t r;
        int edges_left;
        int queries_left;
        edges_left   = n_edges;
        queries_left = n_queries;
        while (edges_left + queries_left > 0)
        begin
            if (queries_left == 0 ||
                (edges_left > 0 && $urandom_range(edges_left + queries_left - 1) < edges_left))
            begin
                r.action = ACT_EDGE;
                edges_left--;
            end
            else
            begin
                r.action = ACT_QUERY;
                queries_left--;
            end
            r.node_a = pick_node(span, bad_pct);
            r.node_b = pick_node(span, bad_pct);
            // mostly short lengths so limits cut between edges, some full width
            if ($urandom_range(9) == 0)
                r.len = LEN_W'($urandom);
            else
                r.len = LEN_W'($urandom_range(24));
            r.last       = (edges_left + queries_left == 0);
            r.typed_conn = -1;
            r.cfg        = -1;
            send_request(r);
        end
    endtask

    // a run of random problems under one node_count
    task automatic random_block(int n_items);
        int lim;
        int span;
        int ne;
        int nq;
        int start;
        lim   = node_count < NODES ? int'(node_count) : NODES;
        start = sent_requests;
        while (sent_requests - start < n_items)
        begin
            span = $urandom_range(lim, lim < 4 ? 1 : 4);
            if ($urandom_range(3) == 0)
                span = lim;
            ne = $urandom_range(12);
            nq = $urandom_range(9) == 0 ? 0 : $urandom_range(8, 1);
            if (ne + nq == 0)
                ne = 1;
            run_problem(ne, nq, span, 5);
        end
    endtask

    // hand-written rows; typed answers follow from the strict limit test and
    // from node equality, the rest come from the predictor
    request_t directed_rows[14] = '{
        '{ACT_EDGE,  8'd0,   8'd255, 24'hFFFFFF, 1'b0, -1, -1},
        '{ACT_EDGE,  8'd0,   8'd1,   24'd0,      1'b0, -1, -1},
        '{ACT_QUERY, 8'd0,   8'd1,   24'd0,      1'b0,  0, -1},  // limit not above length
        '{ACT_QUERY, 8'd0,   8'd1,   24'd1,      1'b0,  1, -1},
        '{ACT_QUERY, 8'd0,   8'd255, 24'hFFFFFF, 1'b0,  0, -1},  // longest edge never merged
        '{ACT_QUERY, 8'd255, 8'd255, 24'd0,      1'b0,  1, -1},  // node with itself
        '{ACT_QUERY, 8'd1,   8'd255, 24'hFFFFFF, 1'b1, -1, -1},
        '{ACT_EDGE,  8'd3,   8'd4,   24'd5,      1'b1, -1, -1},  // no queries, no answers
        '{ACT_QUERY, 8'd1,   8'd2,   24'd0,      1'b1,  0, -1},
        '{ACT_EDGE,  8'd0,   8'd0,   24'd7,      1'b0, -1,  1},  // single node from here
        '{ACT_QUERY, 8'd0,   8'd0,   24'd0,      1'b0,  1, -1},
        '{ACT_QUERY, 8'd1,   8'd0,   24'd3,      1'b0, -1, -1},  // bad node, dropped
        '{ACT_EDGE,  8'd0,   8'd1,   24'd2,      1'b0, -1, -1},  // bad node, dropped
        '{ACT_QUERY, 8'd0,   8'd200, 24'd9,      1'b1, -1, -1}   // dropped last still solves
    };

    initial
    begin
        int recv_modes [4] = '{0, 0, 52, 24};
        int send_modes [4] = '{0, 52, 0, 24};
        int counts [4][2]  = '{'{256, 1}, '{2, 200}, '{256, 16}, '{0, 256}};
        int cnt;

        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_wdata              = '0;
        req_if.valid           = 1'b0;
        req_if.action          = ACT_EDGE;
        req_if.node_a          = '0;
        req_if.node_b          = '0;
        req_if.length_or_limit = '0;
        req_if.last            = 1'b0;
        ans_if.ready           = 1'b0;
        send_idle_pct          = 0;
        recv_stall_pct         = 0;
        hold_left              = 0;
        hold_start             = 1'b0;
        error_count            = 0;
        idle_cycles            = 0;
        sent_requests          = 0;
        node_count             = NODE_COUNT_RESET;
        clear_problem();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].cfg >= 0)
                load_node_count(directed_rows[i].cfg);
            send_request(directed_rows[i]);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            for (int c = 0; c < 2; c++)
            begin
                cnt = counts[ph][c] == 0 ? $urandom_range(256, 1) : counts[ph][c];
                load_node_count(cnt);
                send_idle_pct  = send_modes[ph];
                recv_stall_pct = recv_modes[ph];
                if (ph == 0 && c == 0)
                begin
                    // store full: edges past capacity, then queries past capacity
                    run_problem(EDGE_CAP + 3, 2, NODES, 0);
                    run_problem(0, QUERY_CAP + 2, NODES, 0);
                end
                if (ph == 2 && c == 0)
                begin
                    // answers held back while the next problem keeps arriving
                    hold_start = 1'b1;
                    run_problem(6, 10, 32, 0);
                    run_problem(4, 10, 32, 0);
                end
                random_block(10);
            end
        end

        drain();
        if (answers_due.size() != 0)
        begin
            $error("answers still due at the end: %0d", answers_due.size());
            error_count++;
        end
        if (error_count == 0)
            $display("limited_length_path_connectivity_tb: done, clean");
        else
            $display("limited_length_path_connectivity_tb: done, errors");
        $finish;
    end
endmodule
